FILE: rtl/asf_pkg.sv
// Shared widths, constants, register indexes and control types of the frame scheduler.
`timescale 1ns / 1ps

package asf_pkg;

    // Field widths
    localparam int PTS_W        = 40;
    localparam int ACLK_W       = 40;
    localparam int PEND_W       = 24;
    localparam int NOW_W        = 52;
    localparam int TIMER_W      = 53;
    localparam int DELAY_W      = 21;
    localparam int MS_W         = 16;
    localparam int FRAME_SLOT_W = 2;

    // Configuration registers
    localparam int SYNC_THR_W   = 20;
    localparam int NOSYNC_THR_W = 27;
    localparam int RATE_W       = 18;
    localparam int CHAN_W       = 4;
    localparam int CFG_DATA_W   = 27;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOSYNC_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PRESENT = 3'd4;

    localparam int SYNC_THR_RESET   = 10000;
    localparam int NOSYNC_THR_RESET = 10000000;
    localparam int RATE_RESET       = 48000;
    localparam int CHAN_RESET       = 2;

    // Picture queue
    localparam int QUEUE_DEPTH = 4;
    localparam int RSLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Arithmetic constants, all in microseconds or milliseconds
    localparam int US_PER_S             = 1000000;
    localparam int MAX_DELAY_US         = 1000000;
    localparam int DELAY_RESET_US       = 40000;
    localparam int MIN_WAIT_US          = 10000;
    localparam int ROUND_US             = 500;
    localparam int US_PER_MS            = 1000;
    localparam int SAT_WAIT_US          = 65535500;
    localparam int INTERVAL_NO_VIDEO_MS = 10;
    localparam int INTERVAL_NO_FRAME_MS = 1;

    // Internal datapath widths
    localparam int US_CONST_W = 20;
    localparam int PROD_W     = PEND_W + US_CONST_W;
    localparam int BPS_W      = 23;
    localparam int DIFF_W     = 46;
    localparam int WAIT_W     = TIMER_W + 1;
    localparam int MSDVD_W    = 26;

    // Millisecond rounding by reciprocal: floor(x / 1000) = (x * ceil(2^36 / 1000)) >> 36,
    // exact for every x below 2^26
    localparam int RECIP_W   = 27;
    localparam int MS_RECIP  = 68719477;
    localparam int MS_SHIFT  = 36;
    localparam int MS_PROD_W = MSDVD_W + RECIP_W;

    // Serial divider for the buffer correction
    localparam int DIV_DVD_W = PROD_W;
    localparam int DIV_DVS_W = BPS_W;
    localparam int DIV_CNT_W = 6;
    localparam int REF_ITERS = DIV_DVD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REF_START,
        ST_REF_WAIT,
        ST_DIFF,
        ST_CORR,
        ST_TIMER,
        ST_WAIT,
        ST_CLAMP,
        ST_MS_MUL,
        ST_MS_TAKE,
        ST_DONE
    } asf_state_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic div_start;
        logic ms_mul;
        logic take_q;
        logic diff;
        logic corr;
        logic timer;
        logic wait_calc;
        logic clamp;
        logic take_ms;
        logic finish;
    } asf_cmd_t;

    typedef struct packed {
        logic early;
        logic need_div;
        logic div_done;
        logic out_free;
    } asf_stat_t;

endpackage

FILE: rtl/asf_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module asf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [asf_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [asf_pkg::DIV_DVS_W-1:0] divisor,
    input  logic [asf_pkg::DIV_CNT_W-1:0] iters,
    output logic                          done,
    output logic [asf_pkg::DIV_DVD_W-1:0] quotient
);
    import asf_pkg::*;

    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DVS_W:0]   rem_shift;
    logic [DIV_DVS_W:0]   rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_next  = fits ? rem_sub[DIV_DVS_W-1:0] : rem_shift[DIV_DVS_W-1:0];
        quo_next  = {quo_reg[DIV_DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/asf_dp.sv
// Datapath: configuration, scheduler state, sync correction and output register.
`timescale 1ns / 1ps

module asf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  asf_pkg::asf_cmd_t              cmd,
    output asf_pkg::asf_stat_t             stat,
    input  logic                           cfg_we,
    input  logic [asf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           mode,
    input  logic                           video_present,
    input  logic                           frame_ready,
    input  logic [asf_pkg::PTS_W-1:0]      frame_pts_us,
    input  logic [asf_pkg::ACLK_W-1:0]     audio_clock_us,
    input  logic [asf_pkg::PEND_W-1:0]     audio_bytes_pending,
    input  logic [asf_pkg::NOW_W-1:0]      now_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [asf_pkg::MS_W-1:0]       interval_ms,
    output logic                           show_frame,
    output logic [asf_pkg::FRAME_SLOT_W-1:0] frame_slot,
    output logic [asf_pkg::DELAY_W-1:0]    applied_delay_us
);
    import asf_pkg::*;

    // Configuration
    logic [SYNC_THR_W-1:0]   sync_thr_reg;
    logic [NOSYNC_THR_W-1:0] nosync_thr_reg;
    logic [RATE_W-1:0]       sample_rate_reg;
    logic [CHAN_W-1:0]       channel_count_reg;
    logic                    audio_present_reg;

    // Scheduler state
    logic [TIMER_W-1:0] ft_reg;
    logic [PTS_W-1:0]   last_pts_reg;
    logic [DELAY_W-1:0] last_delay_reg;
    logic [RSLOT_W-1:0] read_slot_reg;

    // Captured word
    logic              mode_reg;
    logic              video_reg;
    logic              fready_reg;
    logic [PTS_W-1:0]  pts_reg;
    logic [ACLK_W-1:0] aclk_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [NOW_W-1:0]  now_reg;

    // Working registers
    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] thr_reg;
    logic [BPS_W-1:0]   bps_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  q_reg;
    logic [DIFF_W-1:0]  diff_reg;
    logic [DELAY_W-1:0] cdelay_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic [MSDVD_W-1:0] dvd_reg;
    logic               sat_reg;
    logic [MS_PROD_W-1:0] ms_prod_reg;

    // Pending result
    logic [MS_W-1:0]    res_ms_reg;
    logic               res_show_reg;
    logic [DELAY_W-1:0] res_delay_reg;

    // Output register
    logic                    out_valid_reg;
    logic [MS_W-1:0]         out_ms_reg;
    logic                    out_show_reg;
    logic [FRAME_SLOT_W-1:0] out_slot_reg;
    logic [DELAY_W-1:0]      out_delay_reg;

    // Combinational terms
    logic [PTS_W:0]         d_raw;
    logic                   delay_ok;
    logic [DELAY_W-1:0]     delay_pick;
    logic [BPS_W-2:0]       bps_half;
    logic [DIFF_W-1:0]      diff_calc;
    logic [DELAY_W-1:0]     thr_calc;
    logic                   neg;
    logic [DIFF_W-1:0]      adiff;
    logic                   ge_thr;
    logic                   in_range;
    logic                   lag;
    logic                   lead;
    logic [DELAY_W-1:0]     cdelay_calc;
    logic                   wait_low;
    logic                   wait_sat;
    logic                   div_done;
    logic [DIV_DVD_W-1:0]   div_quo;

    always_comb
    begin
        d_raw      = {1'b0, pts_reg} - {1'b0, last_pts_reg};
        delay_ok   = !d_raw[PTS_W] && (d_raw != '0) &&
                     (d_raw < (PTS_W + 1)'(MAX_DELAY_US));
        delay_pick = delay_ok ? DELAY_W'(d_raw) : last_delay_reg;
        bps_half   = (BPS_W - 1)'(sample_rate_reg) * (BPS_W - 1)'(channel_count_reg);

        diff_calc  = DIFF_W'(pts_reg) - DIFF_W'(aclk_reg) + DIFF_W'(q_reg);
        thr_calc   = (delay_reg > DELAY_W'(sync_thr_reg)) ? delay_reg
                                                          : DELAY_W'(sync_thr_reg);

        neg      = diff_reg[DIFF_W-1];
        adiff    = neg ? (DIFF_W'(0) - diff_reg) : diff_reg;
        ge_thr   = adiff >= DIFF_W'(thr_reg);
        in_range = adiff < DIFF_W'(nosync_thr_reg);
        // video lags: diff <= -thr, which a zero diff meets only with a zero threshold
        lag      = (neg && ge_thr) || ((adiff == '0) && (thr_reg == '0));
        lead     = !lag && !neg && ge_thr;
        if (in_range && lag)
            cdelay_calc = '0;
        else if (in_range && lead)
            cdelay_calc = {delay_reg[DELAY_W-2:0], 1'b0};
        else
            cdelay_calc = delay_reg;

        wait_low = wait_reg[WAIT_W-1] || (wait_reg < WAIT_W'(MIN_WAIT_US));
        wait_sat = !wait_reg[WAIT_W-1] && (wait_reg >= WAIT_W'(SAT_WAIT_US));
    end

    asf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (bps_reg),
        .iters    (DIV_CNT_W'(REF_ITERS)),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration, scheduler state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_thr_reg      <= SYNC_THR_W'(SYNC_THR_RESET);
            nosync_thr_reg    <= NOSYNC_THR_W'(NOSYNC_THR_RESET);
            sample_rate_reg   <= RATE_W'(RATE_RESET);
            channel_count_reg <= CHAN_W'(CHAN_RESET);
            audio_present_reg <= 1'b1;
            ft_reg            <= '0;
            last_pts_reg      <= '0;
            last_delay_reg    <= DELAY_W'(DELAY_RESET_US);
            read_slot_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SYNC_THR:      sync_thr_reg      <= cfg_data[SYNC_THR_W-1:0];
                    CFG_NOSYNC_THR:    nosync_thr_reg    <= cfg_data[NOSYNC_THR_W-1:0];
                    CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data[RATE_W-1:0];
                    CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_W-1:0];
                    CFG_AUDIO_PRESENT: audio_present_reg <= cfg_data[0];
                    default:           ;
                endcase
            end

            if (cmd.decide && mode_reg)
                ft_reg <= TIMER_W'(now_reg);
            else if (cmd.timer)
                ft_reg <= ft_reg + TIMER_W'(cdelay_reg);

            if (cmd.decide && !mode_reg && video_reg && fready_reg)
            begin
                last_delay_reg <= delay_pick;
                last_pts_reg   <= pts_reg;
            end

            if (cmd.finish && res_show_reg)
            begin
                if (read_slot_reg == RSLOT_W'(QUEUE_DEPTH - 1))
                    read_slot_reg <= '0;
                else
                    read_slot_reg <= read_slot_reg + 1'b1;
            end

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            video_reg  <= video_present;
            fready_reg <= frame_ready;
            pts_reg    <= frame_pts_us;
            aclk_reg   <= audio_clock_us;
            pend_reg   <= audio_bytes_pending;
            now_reg    <= now_us;
        end

        if (cmd.decide)
        begin
            res_show_reg  <= 1'b0;
            res_delay_reg <= '0;
            if (mode_reg)
                res_ms_reg <= '0;
            else if (!video_reg)
                res_ms_reg <= MS_W'(INTERVAL_NO_VIDEO_MS);
            else
                res_ms_reg <= MS_W'(INTERVAL_NO_FRAME_MS);
            delay_reg <= delay_pick;
            bps_reg   <= {bps_half, 1'b0};
            prod_reg  <= PROD_W'(pend_reg) * PROD_W'(US_PER_S);
            q_reg     <= '0;
        end

        if (cmd.take_q)
            q_reg <= div_quo;

        if (cmd.diff)
        begin
            diff_reg <= diff_calc;
            thr_reg  <= thr_calc;
        end

        if (cmd.corr)
            cdelay_reg <= cdelay_calc;

        if (cmd.wait_calc)
            wait_reg <= {1'b0, ft_reg} - WAIT_W'(now_reg);

        if (cmd.clamp)
        begin
            sat_reg <= wait_sat;
            dvd_reg <= wait_low ? MSDVD_W'(MIN_WAIT_US + ROUND_US)
                                : wait_reg[MSDVD_W-1:0] + MSDVD_W'(ROUND_US);
        end

        if (cmd.ms_mul)
            ms_prod_reg <= MS_PROD_W'(dvd_reg) * MS_PROD_W'(MS_RECIP);

        if (cmd.take_ms)
        begin
            res_ms_reg    <= sat_reg ? '1 : ms_prod_reg[MS_SHIFT +: MS_W];
            res_show_reg  <= 1'b1;
            res_delay_reg <= cdelay_reg;
        end

        if (cmd.finish)
        begin
            out_ms_reg    <= res_ms_reg;
            out_show_reg  <= res_show_reg;
            out_slot_reg  <= res_show_reg ? FRAME_SLOT_W'(read_slot_reg) : '0;
            out_delay_reg <= res_delay_reg;
        end
    end

    always_comb
    begin
        stat.early    = mode_reg || !video_reg || !fready_reg;
        stat.need_div = audio_present_reg && (bps_reg != '0);
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign interval_ms      = out_ms_reg;
    assign show_frame       = out_show_reg;
    assign frame_slot       = out_slot_reg;
    assign applied_delay_us = out_delay_reg;

endmodule

FILE: rtl/asf_ctrl.sv
// Controller: sequences one refresh event through the datapath.
`timescale 1ns / 1ps

module asf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  asf_pkg::asf_stat_t  stat,
    output asf_pkg::asf_cmd_t   cmd
);
    import asf_pkg::*;

    asf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:    state_next = stat.early ? ST_DONE : ST_REF_START;
            ST_REF_START: state_next = stat.need_div ? ST_REF_WAIT : ST_DIFF;
            ST_REF_WAIT:  if (stat.div_done) state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_CORR;
            ST_CORR:      state_next = ST_TIMER;
            ST_TIMER:     state_next = ST_WAIT;
            ST_WAIT:      state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_MS_MUL;
            ST_MS_MUL:    state_next = ST_MS_TAKE;
            ST_MS_TAKE:   state_next = ST_DONE;
            ST_DONE:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE:    cmd.decide = 1'b1;
            ST_REF_START: cmd.div_start = stat.need_div;
            ST_REF_WAIT:  cmd.take_q = stat.div_done;
            ST_DIFF:      cmd.diff = 1'b1;
            ST_CORR:      cmd.corr = 1'b1;
            ST_TIMER:     cmd.timer = 1'b1;
            ST_WAIT:      cmd.wait_calc = 1'b1;
            ST_CLAMP:     cmd.clamp = 1'b1;
            ST_MS_MUL:    cmd.ms_mul = 1'b1;
            ST_MS_TAKE:   cmd.take_ms = 1'b1;
            ST_DONE:      cmd.finish = stat.out_free;
            default:      ;
        endcase
    end

endmodule

FILE: rtl/av_sync_frame_scheduler.sv
// Top level of the audio-locked video refresh scheduler.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | mode, video_present, frame_ready,
//           |           |                      | frame_pts_us, audio_clock_us,
//           |           |                      | audio_bytes_pending, now_us
//   out     | output    | out_valid / out_ready| interval_ms, show_frame, frame_slot,
//           |           |                      | applied_delay_us
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// Flow: one word at a time. A restart, no-video or empty-queue word skips the correction and
// the rounding. A shown frame runs the full sequence; the audio buffer correction runs a serial
// divider for pending bytes / byte rate that works out 44 quotient bits, and the rounding to
// milliseconds is a reciprocal multiply.
// Reset: rst_n clears the scheduler state and restores the register defaults at once.
// Stalls: the result sits in an output register, so the next word is accepted while it
// waits; a word finished behind a stalled result holds until out_ready frees the register.
`timescale 1ns / 1ps

module av_sync_frame_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [asf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // refresh event in
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic                             video_present,
    input  logic                             frame_ready,
    input  logic [asf_pkg::PTS_W-1:0]        frame_pts_us,
    input  logic [asf_pkg::ACLK_W-1:0]       audio_clock_us,
    input  logic [asf_pkg::PEND_W-1:0]       audio_bytes_pending,
    input  logic [asf_pkg::NOW_W-1:0]        now_us,
    // schedule out
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [asf_pkg::MS_W-1:0]         interval_ms,
    output logic                             show_frame,
    output logic [asf_pkg::FRAME_SLOT_W-1:0] frame_slot,
    output logic [asf_pkg::DELAY_W-1:0]      applied_delay_us
);
    import asf_pkg::*;

    asf_cmd_t  cmd;
    asf_stat_t stat;

    // Sequence the word: decide the special cases, pick the frame delay, run the
    // buffer-correction divide, correct against the audio clock, advance the frame
    // timer, then scale the wait down to rounded milliseconds.
    asf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold configuration, frame timer, last timestamp, last delay and queue slot;
    // drive the output register.
    asf_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mode                (mode),
        .video_present       (video_present),
        .frame_ready         (frame_ready),
        .frame_pts_us        (frame_pts_us),
        .audio_clock_us      (audio_clock_us),
        .audio_bytes_pending (audio_bytes_pending),
        .now_us              (now_us),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .interval_ms         (interval_ms),
        .show_frame          (show_frame),
        .frame_slot          (frame_slot),
        .applied_delay_us    (applied_delay_us)
    );

endmodule

FILE: rtl/asf_checker.sv
// Port-level checker for the frame scheduler, bound to the top level.
`timescale 1ns / 1ps

module asf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [asf_pkg::MS_W-1:0]         interval_ms,
    input logic                             show_frame,
    input logic [asf_pkg::FRAME_SLOT_W-1:0] frame_slot,
    input logic [asf_pkg::DELAY_W-1:0]      applied_delay_us
);
    import asf_pkg::*;

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A word in work blocks the next one: in_ready drops in the cycle after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

    // Unshown results carry no slot and no delay, and only the special intervals
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !show_frame |->
            (frame_slot == '0) && (applied_delay_us == '0) &&
            ((interval_ms == MS_W'(0)) || (interval_ms == MS_W'(INTERVAL_NO_FRAME_MS)) ||
             (interval_ms == MS_W'(INTERVAL_NO_VIDEO_MS))))
        else $error("bad fields on an unshown result");

    // A shown frame waits at least the minimum wait, rounded
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && show_frame |-> interval_ms >= MS_W'(MIN_WAIT_US / US_PER_MS))
        else $error("interval below the minimum wait");

endmodule

bind av_sync_frame_scheduler asf_checker u_asf_checker (.*);
